### src/join_admission_id_allocator_core_defines.svh
`ifndef JOIN_ADMISSION_ID_ALLOCATOR_CORE_DEFINES_SVH
`define JOIN_ADMISSION_ID_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JAIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JAIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/jaia_pkg.sv
package jaia_pkg;

  localparam int NODE_CAPACITY = 128;
  localparam int PENDING_DEPTH = 32;

  localparam int ID_W   = 8;
  localparam int CHIP_W = 32;
  localparam int TBL_AW = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
  localparam int PQ_AW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);

  localparam logic [7:0]  JOIN_TYPE    = 8'd3;
  localparam logic [7:0]  ACK_TYPE     = 8'd4;
  localparam logic [7:0]  JOIN_LENGTH  = 8'd6;
  localparam logic [31:0] WINDOW_RESET = 32'd26500;

  typedef enum logic [2:0] {
    STS_QUEUED  = 3'd0,
    STS_DUP     = 3'd1,
    STS_QFULL   = 3'd2,
    STS_EARLY   = 3'd3,
    STS_BADSUM  = 3'd4,
    STS_NOTJOIN = 3'd5,
    STS_ACK     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOKUP,
    S_QSCAN,
    S_EMIT,
    S_FL_RD,
    S_FL_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CHIP_W-1:0] chip;
  } tbl_req_t;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] id;
  } tbl_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [CHIP_W-1:0] chip_id;
  } pend_t;

  function automatic logic [7:0] fold_bytes(input logic [CHIP_W-1:0] v);
    return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

  function automatic logic [7:0] ack_sum(input logic [CHIP_W-1:0] chip,
                                         input logic [ID_W-1:0] id);
    return ACK_TYPE ^ fold_bytes(chip) ^ id;
  endfunction

endpackage

### src/jaia_node_table.sv
`include "join_admission_id_allocator_core_defines.svh"

module jaia_node_table (
  input  logic               clk,
  input  logic               rst_n,
  input  jaia_pkg::tbl_req_t req,
  output jaia_pkg::tbl_rsp_t rsp
);
  import jaia_pkg::*;

  logic [CHIP_W-1:0] mem [NODE_CAPACITY];

  logic              busy_r, busy_nxt;
  logic [ID_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [ID_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [ID_W-1:0]   next_free_r, next_free_nxt;
  logic [CHIP_W-1:0] chip_r;
  logic [CHIP_W-1:0] q_r;
  logic              done_r, done_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  logic              rd_en, wr_en;
  logic [ID_W-1:0]   rd_full, wr_full;
  logic              match, issue;

  assign match   = cmp_valid_r && (q_r == chip_r);
  assign issue   = scan_idx_r < next_free_r;
  assign rd_full = ID_W'(scan_idx_r - ID_W'(1));
  assign wr_full = ID_W'(next_free_r - ID_W'(1));

  always_comb begin
    busy_nxt      = busy_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    next_free_nxt = next_free_r;
    done_nxt      = 1'b0;
    id_nxt        = id_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    if (req.start) begin
      busy_nxt      = 1'b1;
      scan_idx_nxt  = ID_W'(1);
      cmp_valid_nxt = 1'b0;
    end else if (busy_r) begin
      if (match) begin
        done_nxt      = 1'b1;
        id_nxt        = cmp_idx_r;
        busy_nxt      = 1'b0;
        cmp_valid_nxt = 1'b0;
      end else if (issue) begin
        rd_en         = 1'b1;
        scan_idx_nxt  = ID_W'(scan_idx_r + ID_W'(1));
        cmp_valid_nxt = 1'b1;
        cmp_idx_nxt   = scan_idx_r;
      end else begin
        done_nxt      = 1'b1;
        busy_nxt      = 1'b0;
        cmp_valid_nxt = 1'b0;
        if (next_free_r > ID_W'(NODE_CAPACITY)) begin
          id_nxt = '0;
        end else begin
          wr_en         = 1'b1;
          id_nxt        = next_free_r;
          next_free_nxt = ID_W'(next_free_r + ID_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cmp_valid_r <= 1'b0;
      next_free_r <= ID_W'(1);
      done_r      <= 1'b0;
      scan_idx_r  <= ID_W'(1);
      cmp_idx_r   <= '0;
    end else begin
      busy_r      <= busy_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      next_free_r <= next_free_nxt;
      done_r      <= done_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (req.start) begin
      chip_r <= req.chip;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_full[TBL_AW-1:0]] <= chip_r;
    end
    if (rd_en) begin
      q_r <= mem[rd_full[TBL_AW-1:0]];
    end
  end

  assign rsp.done = done_r;
  assign rsp.id   = id_r;

  `JAIA_ASSERT_NOW(a_start_idle, req.start, !busy_r, "lookup started while busy")
  `JAIA_ASSERT_NOW(a_free_bound, 1'b1, next_free_r <= ID_W'(NODE_CAPACITY + 1),
                   "next free id beyond capacity")
  `JAIA_ASSERT_NOW(a_id_below_free, rsp.done, rsp.id < next_free_r,
                   "returned id not yet allocated")

endmodule

### src/join_admission_id_allocator_core.sv
// Path: a rejected request goes from S_CHECK straight to S_EMIT; an accepted
//   one first scans the node table and then the pending queue RAMs, one
//   entry per cycle, before S_EMIT loads the result when the output is free.
// Flush: each queued entry is read through the pending RAM read port, then emitted.
// One request at a time; in_tready high only in idle, after a result load or empty flush.
// Reset (rst_n, sync): window 26500, ids from 1, queue empty; RAMs not cleared.
`include "join_admission_id_allocator_core_defines.svh"

module join_admission_id_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // packet_type, packet_length, chip_id,
                                  // packet_checksum, elapsed
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // node_id, ack_chip_id, ack_checksum
  output logic [2:0]  out_tuser,  // status
  output logic        out_tlast
);
  import jaia_pkg::*;

  pend_t pmem [PENDING_DEPTH];

  state_t            state_r, state_nxt;
  logic [31:0]       window_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              qcmp_valid_r, qcmp_valid_nxt;
  pend_t             pq_q_r;

  logic              op_r;
  logic [7:0]        type_r, len_r, sum_r;
  logic [CHIP_W-1:0] chip_r;
  logic [31:0]       elapsed_r;

  status_t           res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [CHIP_W-1:0] out_chip_r, out_chip_nxt;
  logic [7:0]        out_sum_r, out_sum_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;

  logic              in_acc, out_free;
  logic              pq_rd_en, pq_wr_en;
  logic              qmatch, qissue, res_ok, fl_last;
  tbl_req_t          tbl_req;
  tbl_rsp_t          tbl_rsp;

  jaia_node_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign qmatch    = qcmp_valid_r && (pq_q_r.chip_id == chip_r);
  assign qissue    = idx_r < count_r;
  assign fl_last   = idx_r == CNT_W'(count_r - CNT_W'(1));
  assign res_ok    = (res_status_r == STS_QUEUED) || (res_status_r == STS_DUP) ||
                     (res_status_r == STS_QFULL);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    qcmp_valid_nxt = qcmp_valid_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    pq_rd_en       = 1'b0;
    pq_wr_en       = 1'b0;
    tbl_req.start  = 1'b0;
    tbl_req.chip   = chip_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_chip_nxt   = out_chip_r;
    out_sum_nxt    = out_sum_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_id_nxt = '0;
        if (op_r) begin
          idx_nxt   = '0;
          state_nxt = (count_r == '0) ? S_IDLE : S_FL_RD;
        end else if (type_r != JOIN_TYPE || len_r != JOIN_LENGTH) begin
          res_status_nxt = STS_NOTJOIN;
          state_nxt      = S_EMIT;
        end else if (elapsed_r < window_r) begin
          res_status_nxt = STS_EARLY;
          state_nxt      = S_EMIT;
        end else if ((type_r ^ fold_bytes(chip_r)) != sum_r) begin
          res_status_nxt = STS_BADSUM;
          state_nxt      = S_EMIT;
        end else begin
          tbl_req.start = 1'b1;
          state_nxt     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (tbl_rsp.done) begin
          res_id_nxt     = tbl_rsp.id;
          idx_nxt        = '0;
          qcmp_valid_nxt = 1'b0;
          state_nxt      = S_QSCAN;
        end
      end
      S_QSCAN: begin
        if (qmatch) begin
          qcmp_valid_nxt = 1'b0;
          res_status_nxt = STS_DUP;
          state_nxt      = S_EMIT;
        end else if (qissue) begin
          pq_rd_en       = 1'b1;
          idx_nxt        = CNT_W'(idx_r + CNT_W'(1));
          qcmp_valid_nxt = 1'b1;
        end else begin
          qcmp_valid_nxt = 1'b0;
          state_nxt      = S_EMIT;
          if (count_r >= CNT_W'(PENDING_DEPTH)) begin
            res_status_nxt = STS_QFULL;
          end else begin
            pq_wr_en       = 1'b1;
            count_nxt      = CNT_W'(count_r + CNT_W'(1));
            res_status_nxt = STS_QUEUED;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_chip_nxt   = chip_r;
          out_sum_nxt    = res_ok ? ack_sum(chip_r, res_id_r) : 8'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FL_RD: begin
        pq_rd_en  = 1'b1;
        state_nxt = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = STS_ACK;
          out_id_nxt     = pq_q_r.node_id;
          out_chip_nxt   = pq_q_r.chip_id;
          out_sum_nxt    = ack_sum(pq_q_r.chip_id, pq_q_r.node_id);
          out_last_nxt   = fl_last;
          if (fl_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = CNT_W'(idx_r + CNT_W'(1));
            state_nxt = S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_r     <= WINDOW_RESET;
      count_r      <= '0;
      idx_r        <= '0;
      qcmp_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      qcmp_valid_r <= qcmp_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser;
      type_r    <= in_tdata[7:0];
      len_r     <= in_tdata[15:8];
      chip_r    <= in_tdata[47:16];
      sum_r     <= in_tdata[55:48];
      elapsed_r <= in_tdata[87:56];
    end
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_chip_r   <= out_chip_nxt;
    out_sum_r    <= out_sum_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (pq_wr_en) begin
      pmem[count_r[PQ_AW-1:0]] <= '{node_id: res_id_r, chip_id: chip_r};
    end
    if (pq_rd_en) begin
      pq_q_r <= pmem[idx_r[PQ_AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sum_r, out_chip_r, out_id_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `JAIA_ASSERT_NOW(a_cnt_range, 1'b1, count_r <= CNT_W'(PENDING_DEPTH),
                   "pending count beyond depth")
  `JAIA_ASSERT_NEXT(a_accept_check, in_acc, state_r == S_CHECK,
                    "request accepted outside idle")
  `JAIA_ASSERT_NEXT(a_flush_clear, state_r == S_FL_EMIT && out_load && out_last_nxt,
                    count_r == '0, "queue not emptied after flush")
  `JAIA_ASSERT_NOW(a_write_room, pq_wr_en, count_r < CNT_W'(PENDING_DEPTH),
                   "enqueue into full queue")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import jaia_pkg::*;

  localparam logic OP_JOIN  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam int   STUCK_LIMIT   = 3000;
  localparam int   SETTLE_CYCLES = 200;
  localparam int   POOL_SIZE     = 40;

  typedef struct {
    status_t     status;
    logic [7:0]  node_id;
    logic [31:0] chip;
    logic [7:0]  csum;
    logic        last;
  } ack_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;   // packet_type, packet_length, chip_id,
                                // packet_checksum, elapsed
  logic        in_tuser = 1'b0; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // node_id, ack_chip_id, ack_checksum
  logic [2:0]  out_tuser;       // status
  logic        out_tlast;

  // model of the admission state
  logic [31:0] window_ms;
  logic [31:0] chip_by_id [1:NODE_CAPACITY];
  int          next_id;
  logic [31:0] queued_chip [PENDING_DEPTH];
  logic [7:0]  queued_id [PENDING_DEPTH];
  int          queued_n;

  ack_t        expected_acks [$];
  logic [31:0] chip_pool [POOL_SIZE];

  int  in_gap;
  bit  in_pace;
  bit  out_pace;
  int  mismatches;
  int  requests_sent;
  int  acks_checked;
  int  stuck;

  always #4 clk = ~clk;

  join_admission_id_allocator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  function automatic logic [7:0] byte_xor(logic [31:0] v);
    return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

  function automatic logic [7:0] reply_sum(logic [31:0] chip, logic [7:0] id);
    return ACK_TYPE ^ byte_xor(chip) ^ id;
  endfunction

  function automatic logic [31:0] on_time();
    longint span;
    span = 64'h1_0000_0000 - longint'(window_ms);
    return 32'(longint'(window_ms) + (longint'($urandom) % span));
  endfunction

  function automatic void push_ack(status_t st, logic [7:0] id, logic [31:0] chip,
                                   logic [7:0] sum, logic last);
    ack_t a;
    a.status  = st;
    a.node_id = id;
    a.chip    = chip;
    a.csum    = sum;
    a.last    = last;
    expected_acks.push_back(a);
  endfunction

  // works out the results one accepted request causes
  function automatic void admit_item(logic op, logic [7:0] ptype, logic [7:0] plen,
                                     logic [31:0] chip, logic [7:0] psum,
                                     logic [31:0] elapsed);
    int  id;
    bit  found;
    bit  dup;
    id = 0;
    found = 0;
    dup = 0;
    if (op == OP_FLUSH) begin
      for (int k = 0; k < queued_n; k++)
        push_ack(STS_ACK, queued_id[k], queued_chip[k],
                 reply_sum(queued_chip[k], queued_id[k]), k == queued_n - 1);
      queued_n = 0;
      return;
    end
    if (ptype != JOIN_TYPE || plen != JOIN_LENGTH) begin
      push_ack(STS_NOTJOIN, 8'd0, chip, 8'd0, 1'b1);
      return;
    end
    if (elapsed < window_ms) begin
      push_ack(STS_EARLY, 8'd0, chip, 8'd0, 1'b1);
      return;
    end
    if ((JOIN_TYPE ^ byte_xor(chip)) != psum) begin
      push_ack(STS_BADSUM, 8'd0, chip, 8'd0, 1'b1);
      return;
    end
    for (int i = 1; i < next_id && i <= NODE_CAPACITY; i++)
      if (!found && chip_by_id[i] == chip) begin
        id = i;
        found = 1;
      end
    if (!found && next_id <= NODE_CAPACITY) begin
      chip_by_id[next_id] = chip;
      id = next_id;
      next_id++;
    end
    for (int k = 0; k < queued_n; k++)
      if (queued_chip[k] == chip) dup = 1;
    if (dup) begin
      push_ack(STS_DUP, 8'(id), chip, reply_sum(chip, 8'(id)), 1'b1);
    end else if (queued_n >= PENDING_DEPTH) begin
      push_ack(STS_QFULL, 8'(id), chip, reply_sum(chip, 8'(id)), 1'b1);
    end else begin
      queued_chip[queued_n] = chip;
      queued_id[queued_n] = 8'(id);
      queued_n++;
      push_ack(STS_QUEUED, 8'(id), chip, reply_sum(chip, 8'(id)), 1'b1);
    end
  endfunction

  task automatic send_item(logic op, logic [7:0] ptype, logic [7:0] plen,
                           logic [31:0] chip, logic [7:0] psum, logic [31:0] elapsed);
    repeat (in_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {elapsed, psum, chip, plen, ptype};
    do @(posedge clk); while (!in_tready);
    admit_item(op, ptype, plen, chip, psum, elapsed);
    requests_sent++;
    if ($urandom_range(0, 39) == 0) in_pace = !in_pace;
    in_gap = in_pace ? $urandom_range(0, 8) : 0;
    if (in_gap != 0) in_tvalid <= 1'b0;
  endtask

  task automatic send_join(logic [31:0] chip, logic [31:0] elapsed);
    send_item(OP_JOIN, JOIN_TYPE, JOIN_LENGTH, chip, JOIN_TYPE ^ byte_xor(chip), elapsed);
  endtask

  task automatic send_flush();
    send_item(OP_FLUSH, 8'($urandom), 8'($urandom), $urandom, 8'($urandom), $urandom);
  endtask

  // stop the request side, drain all results and let the block go idle
  task automatic settle();
    if (in_gap == 0) in_tvalid <= 1'b0;
    in_gap = 0;
    while (expected_acks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    window_ms = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] c;
    c = $urandom;
    send_flush();
    send_item(OP_JOIN, 8'd0, JOIN_LENGTH, c, JOIN_TYPE ^ byte_xor(c), 32'hFFFF_FFFF);
    send_item(OP_JOIN, 8'd255, 8'd128, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_JOIN, JOIN_TYPE, 8'd0, c, JOIN_TYPE ^ byte_xor(c), 32'd30000);
    send_item(OP_JOIN, JOIN_TYPE, 8'd5, c, JOIN_TYPE ^ byte_xor(c), 32'd30000);
    send_join(c, 32'd0);
    send_join(c, WINDOW_RESET - 1);
    send_item(OP_JOIN, JOIN_TYPE, JOIN_LENGTH, c, ~(JOIN_TYPE ^ byte_xor(c)), WINDOW_RESET);
    send_join(32'd0, WINDOW_RESET);
    send_join(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_join(32'd0, 32'd40000);
    send_join(c, 32'd50000);
    send_flush();
    send_join(32'd0, WINDOW_RESET);
    send_join(32'hFFFF_FFFF, WINDOW_RESET);
    send_join($urandom, on_time());
    send_flush();
    send_flush();
  endtask

  task automatic test_window();
    write_window(32'd0);
    send_join($urandom, 32'd0);
    send_join($urandom, $urandom);
    write_window(32'hFFFF_FFFF);
    send_join($urandom, 32'hFFFF_FFFE);
    send_join($urandom, 32'hFFFF_FFFF);
    write_window($urandom);
    send_join($urandom, on_time());
    send_join($urandom, window_ms - 1);
    send_flush();
  endtask

  task automatic test_queue_full();
    logic [31:0] first_chip;
    write_window($urandom_range(0, 100000));
    first_chip = $urandom;
    send_join(first_chip, on_time());
    for (int i = 1; i < PENDING_DEPTH + 3; i++) send_join($urandom, on_time());
    send_join(first_chip, on_time());
    send_flush();
    send_join(first_chip, on_time());
    send_flush();
  endtask

  task automatic test_random(int count);
    int          r;
    logic [31:0] c;
    write_window($urandom_range(0, 60000));
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      c = chip_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 10)
        send_flush();
      else if (r < 60)
        send_join(c, on_time());
      else if (r < 70)
        send_join($urandom, on_time());
      else if (r < 78 && window_ms != 0)
        send_join(c, $urandom % window_ms);
      else if (r < 86)
        send_item(OP_JOIN, JOIN_TYPE, JOIN_LENGTH, c,
                  JOIN_TYPE ^ byte_xor(c) ^ 8'($urandom_range(1, 255)), on_time());
      else
        send_item(OP_JOIN, 8'($urandom), 8'($urandom_range(0, 128)), $urandom,
                  8'($urandom), $urandom);
    end
  endtask

  task automatic test_table_full();
    write_window(32'd0);
    while (next_id <= NODE_CAPACITY) begin
      if (queued_n == PENDING_DEPTH) send_flush();
      send_join($urandom, $urandom);
    end
    send_join($urandom, $urandom);
    send_join($urandom, $urandom);
    send_join(chip_pool[0], $urandom);
    send_flush();
  endtask

  always begin
    int stall;
    wait (rst_n);
    if ($urandom_range(0, 39) == 0) out_pace = !out_pace;
    stall = out_pace ? $urandom_range(0, 8) : 0;
    if (stall != 0) begin
      out_tready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_tready <= 1'b1;
    do @(posedge clk); while (!out_tvalid);
    acks_checked++;
    if (expected_acks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result status %0d tdata %h last %b",
                 $realtime, out_tuser, out_tdata, out_tlast);
    end else begin
      ack_t want;
      want = expected_acks.pop_front();
      if (out_tuser !== want.status || out_tdata[7:0] !== want.node_id ||
          out_tdata[39:8] !== want.chip || out_tdata[47:40] !== want.csum ||
          out_tlast !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp st %0d id %0d chip %h sum %h last %b",
                   $realtime, want.status, want.node_id, want.chip, want.csum,
                   want.last);
          $display("    got st %0d id %0d chip %h sum %h last %b",
                   out_tuser, out_tdata[7:0], out_tdata[39:8], out_tdata[47:40],
                   out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    window_ms = WINDOW_RESET;
    next_id = 1;
    queued_n = 0;
    in_gap = 0;
    in_pace = 1;
    out_pace = 1;
    mismatches = 0;
    requests_sent = 0;
    acks_checked = 0;
    stuck = 0;
    for (int i = 0; i < POOL_SIZE; i++) chip_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window();
    test_queue_full();
    test_random(330);
    test_table_full();
    test_random(40);
    settle();
    mismatches += expected_acks.size();
    $display("Ran %0d requests and flushes, checked %0d results;", requests_sent, acks_checked);
    $display("window extremes, queue overflow and node table exhaustion were exercised.");
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
